/* rtl/core/sts_pkg.sv */
// Shared types and constants for the software timer scheduler.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int DELAY_BITS_DEF = 32;
	localparam int MAX_RESULTS    = 16;
	localparam int QUEUE_DEPTH    = 2;

	// input function codes
	localparam logic [1:0] FUNC_CREATE = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef enum logic [1:0] {
		CMD_CREATE,
		CMD_DELETE,
		CMD_TICK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        repeat_req;
		logic [3:0]  tid;
		logic        tid_ok;
	} cmd_ctl_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] result_id;
		logic       fired;
		logic [4:0] active_count;
		logic       last;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FIND,
		BK_TICK,
		BK_FLUSH
	} back_state_t;

endpackage

`default_nettype wire

/* rtl/core/sts_fifo.sv */
// Small first-in first-out queue of beats, used between the block's parts.
// Depends on sts_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module sts_fifo
	import sts_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = store_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sts_front.sv */
// Front end: accepts input beats, classifies them and queues commands.
// Depends on sts_pkg and sts_fifo.
`timescale 1ns / 1ps
`default_nettype none

module sts_front
	import sts_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	parameter int DELAY_BITS = DELAY_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            func,
	input  wire logic [31:0]           delay,
	input  wire logic                  repeat_req,
	input  wire logic [3:0]            target_slot,
	output logic                       cmd_valid,
	output cmd_ctl_t                   cmd_ctl,
	output logic [DELAY_BITS-1:0]      cmd_delay,
	input  wire logic                  cmd_pop
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CMP_W = ((IDX_W > 4) ? IDX_W : 4) + 1;
	localparam int DW    = (DELAY_BITS > 32) ? DELAY_BITS : 32;
	localparam int CTL_W = $bits(cmd_ctl_t);
	localparam int CMD_W = CTL_W + DELAY_BITS;

	logic [DW-1:0]    delay_w;
	cmd_ctl_t         ctl;
	logic             known;
	logic             accept;
	logic             q_empty;
	logic [CMD_W-1:0] q_dout;

	assign delay_w = DW'(delay);
	assign accept  = push && !full;

	always_comb begin
		ctl.kind       = CMD_TICK;
		ctl.repeat_req = repeat_req;
		ctl.tid        = target_slot;
		ctl.tid_ok     = (CMP_W'(target_slot) < CMP_W'(NUM_TIMERS));
		known          = 1'b1;
		unique case (func)
			FUNC_CREATE: ctl.kind = CMD_CREATE;
			FUNC_DELETE: ctl.kind = CMD_DELETE;
			FUNC_TICK:   ctl.kind = CMD_TICK;
			default:     known = 1'b0;  // drop unused code, no result
		endcase
	end

	sts_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && known),
		.din    ({ctl, delay_w[DELAY_BITS-1:0]}),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign cmd_valid = !q_empty;
	assign cmd_ctl   = cmd_ctl_t'(q_dout[CMD_W-1 -: CTL_W]);
	assign cmd_delay = q_dout[DELAY_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/core/sts_back.sv */
// Back end: executes create, delete and tick commands against the slot table.
// Depends on sts_pkg; holds the slot memory and the active bits.
`timescale 1ns / 1ps
`default_nettype none

module sts_back
	import sts_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	parameter int DELAY_BITS = DELAY_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	input  wire cmd_ctl_t              cmd_ctl,
	input  wire logic [DELAY_BITS-1:0] cmd_delay,
	output logic                       cmd_pop,
	output logic                       res_push,
	output res_t                       res_data,
	input  wire logic                  res_full
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int IDW   = (IDX_W > 4) ? IDX_W : 4;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
	localparam int K_W   = $clog2(MAX_RESULTS + 1);
	localparam int DB    = DELAY_BITS;
	localparam int EW    = 2 * DB + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

	// slot entry: {periodic, period, remaining}
	logic [EW-1:0]         mem_q [NUM_TIMERS];
	logic [EW-1:0]         rd_s1;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [EW-1:0]         wr_data;

	back_state_t           state_q, state_d;
	logic [IDX_W-1:0]      idx_q, idx_d;
	logic [IDX_W-1:0]      idx_s1, idx_s1_d;
	logic [NUM_TIMERS-1:0] active_q, active_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [K_W-1:0]        k_q, k_d;
	logic                  hold_valid_q, hold_valid_d;
	res_t                  hold_q, hold_d;

	logic [IDW-1:0]        tid_w;
	logic [IDX_W-1:0]      tid_idx;
	logic                  s1_periodic;
	logic [DB-1:0]         s1_period;
	logic [DB-1:0]         s1_rem;
	logic                  s1_act;
	logic                  s1_due;
	logic                  advance;

	function automatic logic [3:0] to_id(input logic [IDX_W-1:0] i);
		logic [IDW-1:0] w;
		w = IDW'(i);
		return w[3:0];
	endfunction

	function automatic logic [4:0] to_cnt(input logic [CNT_W-1:0] c);
		logic [CW-1:0] w;
		w = CW'(c);
		return w[4:0];
	endfunction

	assign tid_w       = IDW'(cmd_ctl.tid);
	assign tid_idx     = tid_w[IDX_W-1:0];
	assign s1_periodic = rd_s1[EW-1];
	assign s1_period   = rd_s1[2*DB-1 -: DB];
	assign s1_rem      = rd_s1[DB-1:0];
	assign s1_act      = active_q[idx_s1];
	assign s1_due      = s1_act && (s1_rem <= DB'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			idx_q        <= '0;
			idx_s1       <= '0;
			active_q     <= '0;
			count_q      <= '0;
			k_q          <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			idx_s1       <= idx_s1_d;
			active_q     <= active_d;
			count_q      <= count_d;
			k_q          <= k_d;
			hold_valid_q <= hold_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold_d;
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		idx_s1_d     = idx_s1;
		active_d     = active_q;
		count_d      = count_q;
		k_d          = k_q;
		hold_valid_d = hold_valid_q;
		hold_d       = hold_q;
		cmd_pop      = 1'b0;
		res_push     = 1'b0;
		res_data     = '0;
		wr_en        = 1'b0;
		wr_addr      = idx_q;
		wr_data      = '0;
		rd_en        = 1'b0;
		rd_addr      = '0;
		advance      = 1'b1;

		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd_ctl.kind)
						CMD_CREATE: begin
							idx_d   = '0;
							state_d = BK_FIND;
						end
						CMD_DELETE: begin
							if (!res_full) begin
								res_push           = 1'b1;
								cmd_pop            = 1'b1;
								res_data.result_id = cmd_ctl.tid;
								res_data.last      = 1'b1;
								if (cmd_ctl.tid_ok && active_q[tid_idx]) begin
									active_d[tid_idx]     = 1'b0;
									count_d               = count_q - CNT_W'(1);
									res_data.status       = ST_OK;
									res_data.active_count = to_cnt(count_q - CNT_W'(1));
								end else begin
									res_data.status       = ST_NOT_FOUND;
									res_data.active_count = to_cnt(count_q);
								end
							end
						end
						CMD_TICK: begin
							// prime the slot read for the scan
							rd_en        = 1'b1;
							rd_addr      = '0;
							idx_s1_d     = '0;
							k_d          = '0;
							hold_valid_d = 1'b0;
							state_d      = BK_TICK;
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end

			BK_FIND: begin
				if (!active_q[idx_q]) begin
					if (!res_full) begin
						wr_en                 = 1'b1;
						wr_addr               = idx_q;
						wr_data               = {cmd_ctl.repeat_req, cmd_delay, cmd_delay};
						active_d[idx_q]       = 1'b1;
						count_d               = count_q + CNT_W'(1);
						res_push              = 1'b1;
						res_data.status       = ST_OK;
						res_data.result_id    = to_id(idx_q);
						res_data.active_count = to_cnt(count_q + CNT_W'(1));
						res_data.last         = 1'b1;
						cmd_pop               = 1'b1;
						state_d               = BK_IDLE;
					end
				end else if (idx_q == LAST_IDX) begin
					if (!res_full) begin
						res_push              = 1'b1;
						res_data.status       = ST_FULL;
						res_data.active_count = to_cnt(count_q);
						res_data.last         = 1'b1;
						cmd_pop               = 1'b1;
						state_d               = BK_IDLE;
					end
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end

			BK_TICK: begin
				wr_addr = idx_s1;
				if (s1_act && !s1_due) begin
					wr_en   = 1'b1;
					wr_data = {s1_periodic, s1_period, s1_rem - DB'(1)};
				end else if (s1_due && (k_q >= K_W'(MAX_RESULTS))) begin
					// over the result limit: park at zero, fire on a later tick
					wr_en   = 1'b1;
					wr_data = {s1_periodic, s1_period, {DB{1'b0}}};
				end else if (s1_due) begin
					if (hold_valid_q && res_full) begin
						advance = 1'b0;
					end else begin
						if (hold_valid_q) begin
							res_push = 1'b1;
							res_data = hold_q;
						end
						hold_d.status    = ST_OK;
						hold_d.result_id = to_id(idx_s1);
						hold_d.fired     = 1'b1;
						hold_d.last      = 1'b0;
						if (s1_periodic) begin
							wr_en   = 1'b1;
							wr_data = {s1_periodic, s1_period,
								(s1_period == '0) ? DB'(1) : s1_period};
							hold_d.active_count = to_cnt(count_q);
						end else begin
							active_d[idx_s1]    = 1'b0;
							count_d             = count_q - CNT_W'(1);
							hold_d.active_count = to_cnt(count_q - CNT_W'(1));
						end
						hold_valid_d = 1'b1;
						k_d          = k_q + K_W'(1);
					end
				end
				if (advance) begin
					if (idx_s1 == LAST_IDX) begin
						state_d = BK_FLUSH;
					end else begin
						rd_en    = 1'b1;
						rd_addr  = idx_s1 + IDX_W'(1);
						idx_s1_d = idx_s1 + IDX_W'(1);
					end
				end
			end

			BK_FLUSH: begin
				if (!hold_valid_q) begin
					cmd_pop = 1'b1;
					state_d = BK_IDLE;
				end else if (!res_full) begin
					res_push      = 1'b1;
					res_data      = hold_q;
					res_data.last = 1'b1;
					hold_valid_d  = 1'b0;
					cmd_pop       = 1'b1;
					state_d       = BK_IDLE;
				end
			end

			default: state_d = BK_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(active_q)))
		else $error("active count out of step with active bits");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from an empty queue");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= K_W'(MAX_RESULTS))
		else $error("fired count beyond result limit");

	a_hold_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> (state_q == BK_TICK || state_q == BK_FLUSH))
		else $error("held result outside a tick");
`endif

endmodule

`default_nettype wire

/* rtl/core/software_timer_scheduler.sv */
// Top level of the software timer scheduler: front end, back end, result queue.
// Depends on sts_pkg, sts_fifo, sts_front and sts_back.
`timescale 1ns / 1ps
`default_nettype none

// A table of NUM_TIMERS one-shot or periodic timers driven by tick beats.
// Input beats are queued (two deep) and result beats leave through a
// two-deep queue, so both sides may stall independently. Commands run one
// at a time in the back end: a delete is answered from the idle state, a
// create is dispatched from idle and then searches for the lowest free slot
// at one slot per cycle, and a tick scans every slot through the slot memory
// at one read per cycle while the result side does not stall.
// A tick emits one fired beat per due slot, up to MAX_RESULTS, in ascending
// order, the final one flagged last; due slots beyond it fire on a later tick.
// A tick with nothing due emits nothing.
module software_timer_scheduler
	import sts_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	parameter int DELAY_BITS = DELAY_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] delay,
	input  wire logic        repeat_req,
	input  wire logic [3:0]  target_slot,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       status,
	output logic [3:0]       result_id,
	output logic             fired,
	output logic [4:0]       active_count,
	output logic             last
);

	localparam int RES_W = $bits(res_t);

	logic                  cmd_valid;
	cmd_ctl_t              cmd_ctl;
	logic [DELAY_BITS-1:0] cmd_delay;
	logic                  cmd_pop;
	logic                  res_push;
	res_t                  res_data;
	logic                  res_full;
	logic [RES_W-1:0]      res_dout;
	res_t                  res_head;

	sts_front #(
		.NUM_TIMERS (NUM_TIMERS),
		.DELAY_BITS (DELAY_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.delay       (delay),
		.repeat_req  (repeat_req),
		.target_slot (target_slot),
		.cmd_valid   (cmd_valid),
		.cmd_ctl     (cmd_ctl),
		.cmd_delay   (cmd_delay),
		.cmd_pop     (cmd_pop)
	);

	sts_back #(
		.NUM_TIMERS (NUM_TIMERS),
		.DELAY_BITS (DELAY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ctl   (cmd_ctl),
		.cmd_delay (cmd_delay),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_full  (res_full)
	);

	sts_fifo #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_data),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_dout),
		.empty  (empty)
	);

	assign res_head     = res_t'(res_dout);
	assign status       = res_head.status;
	assign result_id    = res_head.result_id;
	assign fired        = res_head.fired;
	assign active_count = res_head.active_count;
	assign last         = res_head.last;

endmodule

`default_nettype wire

/* sim/software_timer_scheduler_tb.sv */
// Self-checking testbench for software_timer_scheduler: creates, deletes and ticks
// are pushed against a tracked copy of the timer table; every popped beat is checked.
// Depends on sts_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 1ps

module software_timer_scheduler_tb;
	import sts_pkg::*;

	localparam logic [1:0] FUNC_UNUSED  = 2'd3;
	localparam int         N_SLOTS      = NUM_TIMERS_DEF;
	localparam int         RANDOM_ITEMS = 185;
	localparam int         MAX_GAP      = 17;
	localparam int         DRAIN_CYCLES = 100;

	// Tracks the timer table and holds the beats it owes, oldest first.
	class timer_table_tracker;
		bit        live [N_SLOTS];
		bit        periodic [N_SLOTS];
		bit [31:0] period [N_SLOTS];
		bit [31:0] remaining [N_SLOTS];
		res_t      owed [$];

		function bit [4:0] live_total();
			bit [4:0] n;
			n = '0;
			foreach (live[i])
				n += live[i];
			return n;
		endfunction

		function int pick_live();
			int ids [$];
			foreach (live[i])
				if (live[i])
					ids.push_back(i);
			if (ids.size() == 0)
				return -1;
			return ids[$urandom_range(0, ids.size() - 1)];
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void note_command(logic [1:0] f, logic [31:0] d, logic rep,
				logic [3:0] id);
			res_t held;
			bit   have;
			bit   placed;
			have   = 1'b0;
			placed = 1'b0;
			case (f)
			FUNC_CREATE: begin
				for (int i = 0; i < N_SLOTS && !placed; i++) begin
					if (!live[i]) begin
						live[i]      = 1'b1;
						periodic[i]  = rep;
						period[i]    = d;
						remaining[i] = d;
						placed       = 1'b1;
						owed.push_back('{ST_OK, 4'(i), 1'b0, live_total(), 1'b1});
					end
				end
				if (!placed)
					owed.push_back('{ST_FULL, 4'd0, 1'b0, live_total(), 1'b1});
			end
			FUNC_DELETE: begin
				if (live[id]) begin
					live[id] = 1'b0;
					owed.push_back('{ST_OK, id, 1'b0, live_total(), 1'b1});
				end else begin
					owed.push_back('{ST_NOT_FOUND, id, 1'b0, live_total(), 1'b1});
				end
			end
			FUNC_TICK: begin
				for (int i = 0; i < N_SLOTS; i++) begin
					if (!live[i])
						continue;
					if (remaining[i] > 32'd1) begin
						remaining[i] -= 32'd1;
						continue;
					end
					if (periodic[i])
						remaining[i] = (period[i] != 0) ? period[i] : 32'd1;
					else
						live[i] = 1'b0;
					// hold each beat until the next one shows it was not the final one
					if (have)
						owed.push_back(held);
					held = '{ST_OK, 4'(i), 1'b1, live_total(), 1'b0};
					have = 1'b1;
				end
				if (have) begin
					held.last = 1'b1;
					owed.push_back(held);
				end
			end
			default: ;
			endcase
		endfunction

		function bit check_beat(res_t got, output string msg);
			res_t  want;
			string bad;
			if (owed.size() == 0) begin
				msg = $sformatf(
					"beat with nothing owed: st=%0d id=%0d fired=%0d count=%0d last=%0d",
					got.status, got.result_id, got.fired, got.active_count, got.last);
				return 1'b0;
			end
			want = owed.pop_front();
			bad  = "";
			if (got.status !== want.status)
				bad = {bad, " status"};
			if (got.result_id !== want.result_id)
				bad = {bad, " result_id"};
			if (got.fired !== want.fired)
				bad = {bad, " fired"};
			if (got.active_count !== want.active_count)
				bad = {bad, " active_count"};
			if (got.last !== want.last)
				bad = {bad, " last"};
			if (bad == "")
				return 1'b1;
			msg = $sformatf({"wrong%s: want st=%0d id=%0d f=%0d n=%0d l=%0d,",
				" got st=%0d id=%0d f=%0d n=%0d l=%0d"},
				bad, want.status, want.result_id, want.fired, want.active_count, want.last,
				got.status, got.result_id, got.fired, got.active_count, got.last);
			return 1'b0;
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        push         = 1'b0;
	logic        full;
	logic [1:0]  func         = FUNC_TICK;
	logic [31:0] delay        = '0;
	logic        repeat_req   = 1'b0;
	logic [3:0]  target_slot  = '0;
	logic        empty;
	logic        pop          = 1'b0;
	logic [1:0]  status;
	logic [3:0]  result_id;
	logic        fired;
	logic [4:0]  active_count;
	logic        last;

	timer_table_tracker book = new;
	int errors     = 0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;

	software_timer_scheduler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.delay        (delay),
		.repeat_req   (repeat_req),
		.target_slot  (target_slot),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.result_id    (result_id),
		.fired        (fired),
		.active_count (active_count),
		.last         (last)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Drive one beat from a falling edge and hold it until the block takes it.
	task automatic issue_cmd(logic [1:0] f, logic [31:0] d, logic rep, logic [3:0] id);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push        <= 1'b1;
		func        <= f;
		delay       <= d;
		repeat_req  <= rep;
		target_slot <= id;
		do @(posedge clk); while (full !== 1'b0);
		book.note_command(f, d, rep, id);
		if ($urandom_range(0, 19) == 0)
			send_burst = ~send_burst;
		@(negedge clk);
	endtask

	task automatic issue_tick();
		issue_cmd(FUNC_TICK, $urandom(), 1'($urandom()), 4'($urandom()));
	endtask

	task automatic random_create();
		int          sel;
		logic [31:0] d;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			d = $urandom();
		else if (sel < 11)
			d = 32'hFFFF_FFFF;
		else
			d = $urandom_range(0, 6);
		issue_cmd(FUNC_CREATE, d, 1'($urandom()), 4'($urandom()));
	endtask

	task automatic random_delete();
		int victim;
		victim = book.pick_live();
		if (victim < 0 || $urandom_range(0, 9) >= 7)
			victim = $urandom_range(0, N_SLOTS - 1);
		issue_cmd(FUNC_DELETE, $urandom(), 1'($urandom()), 4'(victim));
	endtask

	initial begin : result_side
		res_t  got;
		string msg;
		int    stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			got = '{status, result_id, fired, active_count, last};
			if (!book.check_beat(got, msg))
				report_mismatch(msg);
			if ($urandom_range(0, 19) == 0)
				recv_burst = ~recv_burst;
			@(negedge clk);
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int done;
		int pick;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: idle tick, unused code, delete of a free slot
		issue_tick();
		issue_cmd(FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, 4'hF);
		issue_cmd(FUNC_DELETE, 32'd0, 1'b0, 4'd15);
		// zero delay fires on the first tick; a periodic zero reloads as one
		issue_cmd(FUNC_CREATE, 32'd0, 1'b0, 4'd0);
		issue_cmd(FUNC_CREATE, 32'd0, 1'b1, 4'd0);
		issue_cmd(FUNC_CREATE, 32'd2, 1'b1, 4'd0);
		issue_cmd(FUNC_CREATE, 32'hFFFF_FFFF, 1'b0, 4'd0);
		issue_tick();
		issue_tick();
		issue_cmd(FUNC_DELETE, 32'd0, 1'b0, 4'd1);
		issue_cmd(FUNC_DELETE, 32'd0, 1'b0, 4'd1);
		// fill the table, then one create too many
		for (int i = 0; i < 15; i++)
			issue_cmd(FUNC_CREATE, 32'd1, 1'(i), 4'(i));
		// fourteen slots due at once
		issue_tick();
		issue_cmd(FUNC_DELETE, 32'd0, 1'b0, 4'd3);

		done = 0;
		while (done < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				random_create();
			else if (pick < 55)
				random_delete();
			else if (pick < 95)
				issue_tick();
			else
				issue_cmd(FUNC_UNUSED, $urandom(), 1'($urandom()), 4'($urandom()));
			if (pick < 95)
				done++;
		end
		push <= 1'b0;

		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
